/* design/umkn_pkg.sv */
// Shared types, constants and character functions of the match key normalizer.
package umkn_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int HOLD_AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HOLD_CW = $clog2(HOLD_DEPTH + 1);
  localparam int JOB_CPS = 4;

  localparam logic [20:0] FW_FIRST  = 21'h00FF01;
  localparam logic [20:0] FW_LAST   = 21'h00FF5E;
  localparam logic [20:0] FW_OFFSET = 21'h00FEE0;

  typedef logic [20:0] cp_t;

  typedef struct packed {
    cp_t [JOB_CPS-1:0] cps;
    logic [2:0]        cnt;
    logic              last;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  typedef enum logic {
    BK_RUN,
    BK_END
  } back_state_e;

  function automatic cp_t fold_cp(cp_t cp);
    cp_t r;
    r = cp;
    if (cp >= FW_FIRST && cp <= FW_LAST) begin
      r = cp - FW_OFFSET;
    end else begin
      case (cp) inside
        21'h003000: r = 21'h20;
        21'h003001, 21'h003002, 21'h0000B7: r = 21'h2C;
        21'h00300C, 21'h00300E, 21'h003010, 21'h003014: r = 21'h5B;
        21'h00300D, 21'h00300F, 21'h003011, 21'h003015: r = 21'h5D;
        21'h002010, 21'h002011, 21'h002012, 21'h002013,
        21'h002014, 21'h002015, 21'h002212: r = 21'h2D;
        21'h002018, 21'h002019: r = 21'h27;
        21'h00201C, 21'h00201D: r = 21'h22;
        default: r = cp;
      endcase
    end
    return r;
  endfunction

  function automatic enc_t utf8_encode(cp_t cp);
    enc_t e;
    e.b = '0;
    if (cp < 21'h80) begin
      e.n = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic logic is_sep(logic [7:0] b);
    logic r;
    case (b) inside
      8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2C, 8'h3B, 8'h3A,
      8'h2E, 8'h2F, 8'h5C, 8'h2D, 8'h5F, 8'h7C, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* design/umkn_front.sv */
// Front end: UTF-8 decoder that turns accepted bytes into jobs of code points.
module umkn_front import umkn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output job_t       job_o
);

  logic [7:0] pend_q [3];
  logic [7:0] pend_d [3];
  logic [1:0] pc_q, pc_d;
  logic [2:0] el_q, el_d;
  logic       mid_v;
  cp_t        mid;
  logic       rel;
  logic [2:0] n;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    pend_d = pend_q;
    pc_d = pc_q;
    el_d = el_q;
    mid_v = 1'b0;
    mid = '0;
    rel = 1'b0;
    if (pc_q == 2'd0 || in_byte_i[7:6] != 2'b10) begin
      rel = (pc_q != 2'd0);
      if (in_byte_i < 8'hC0) begin
        mid_v = 1'b1;
        mid = {13'd0, in_byte_i};
        pc_d = 2'd0;
        el_d = 3'd0;
      end else begin
        pend_d[0] = in_byte_i;
        pc_d = 2'd1;
        el_d = (in_byte_i >= 8'hF0) ? 3'd4 : ((in_byte_i >= 8'hE0) ? 3'd3 : 3'd2);
      end
    end else if ({1'b0, pc_q} + 3'd1 >= el_q) begin
      mid_v = 1'b1;
      case (el_q)
        3'd2: mid = {10'd0, pend_q[0][4:0], in_byte_i[5:0]};
        3'd3: mid = {5'd0, pend_q[0][3:0], pend_q[1][5:0], in_byte_i[5:0]};
        default: mid = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], in_byte_i[5:0]};
      endcase
      pc_d = 2'd0;
      el_d = 3'd0;
    end else begin
      pend_d[pc_q] = in_byte_i;
      pc_d = pc_q + 2'd1;
    end
  end

  always_comb begin
    job_o = '0;
    n = 3'd0;
    for (int j = 0; j < 3; j++) begin
      if (rel && j < int'(pc_q)) begin
        job_o.cps[n[1:0]] = {13'd0, pend_q[j]};
        n = n + 3'd1;
      end
    end
    if (mid_v) begin
      job_o.cps[n[1:0]] = mid;
      n = n + 3'd1;
    end
    for (int j = 0; j < 3; j++) begin
      if (in_last_i && j < int'(pc_d)) begin
        job_o.cps[n[1:0]] = {13'd0, pend_d[j]};
        n = n + 3'd1;
      end
    end
    job_o.cnt = n;
    job_o.last = in_last_i;
  end

  assign push_o = accept && (in_last_i || n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 2'd0;
      el_q <= 3'd0;
    end else if (accept) begin
      pc_q <= in_last_i ? 2'd0 : pc_d;
      el_q <= in_last_i ? 3'd0 : el_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

/* design/umkn_queue.sv */
// Two-entry job queue between the decoder and the output sequencer.
module umkn_queue import umkn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* design/umkn_back.sv */
// Back end: folding, whitespace collapse, encoding, separator holding and output register.
module umkn_back import umkn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       key_end_o
);

  back_state_e st_q, st_d;

  logic [1:0]         i_q, i_d, k_q, k_d;
  logic               cs_q, cs_d, sw_q, sw_d, lead_q, lead_d;
  logic [7:0]         held_q [HOLD_DEPTH];
  logic [HOLD_AW-1:0] head_q, head_d, head_inc, tail;
  logic [HOLD_CW-1:0] hc_q, hc_d;
  logic [HOLD_CW:0]   tail_sum;
  logic               held_we;
  logic [HOLD_AW-1:0] held_wa;
  logic [7:0]         held_wd;
  logic               lbv_q, lbv_d;
  logic [7:0]         lb_q, lb_d;
  logic               ov_q, ob_present_q, oe_q;
  logic [7:0]         ob_q;
  logic               load, ld_present, ld_end;
  logic [7:0]         ld_byte;

  logic       free, run, ws, has_b, sep, emit, adv, fin, go_end;
  cp_t        fcp;
  enc_t       enc;
  logic [7:0] b, ev;
  logic [2:0] nb;

  assign free = !ov_q || !out_stall_i;
  assign run = (st_q == BK_RUN) && job_valid_i && free;

  always_comb begin
    fcp = fold_cp(job_i.cps[i_q]);
    ws = (fcp == 21'h20) || (fcp >= 21'h09 && fcp <= 21'h0D);
    if (fcp >= 21'h41 && fcp <= 21'h5A) begin
      fcp = fcp + 21'd32;
    end
    enc = utf8_encode(fcp);
    b = ws ? 8'h20 : enc.b[k_q];
    nb = ws ? 3'd1 : enc.n;
    has_b = !ws || (cs_q && !sw_q);
    sep = is_sep(b);
    head_inc = (head_q == HOLD_AW'(HOLD_DEPTH - 1)) ? '0 : head_q + 1'b1;
    tail_sum = (HOLD_CW + 1)'(head_q) + (HOLD_CW + 1)'(hc_q);
    if (tail_sum >= (HOLD_CW + 1)'(HOLD_DEPTH)) begin
      tail_sum = tail_sum - (HOLD_CW + 1)'(HOLD_DEPTH);
    end
    tail = tail_sum[HOLD_AW-1:0];
  end

  always_comb begin
    i_d = i_q;
    k_d = k_q;
    cs_d = cs_q;
    sw_d = sw_q;
    lead_d = lead_q;
    head_d = head_q;
    hc_d = hc_q;
    lbv_d = lbv_q;
    lb_d = lb_q;
    held_we = 1'b0;
    held_wa = tail;
    held_wd = b;
    emit = 1'b0;
    ev = b;
    adv = 1'b0;
    fin = 1'b0;
    go_end = 1'b0;
    pop_o = 1'b0;
    load = 1'b0;
    ld_byte = lb_q;
    ld_present = 1'b1;
    ld_end = 1'b0;
    if (run) begin
      if (job_i.cnt == 3'd0) begin
        fin = 1'b1;
      end else begin
        if (!has_b) begin
          adv = 1'b1;
        end else if (lead_q) begin
          if (!sep) begin
            emit = 1'b1;
            lead_d = 1'b0;
          end
          adv = 1'b1;
        end else if (sep) begin
          adv = 1'b1;
          held_we = 1'b1;
          if (hc_q == HOLD_CW'(HOLD_DEPTH)) begin
            emit = 1'b1;
            ev = held_q[head_q];
            held_wa = head_q;
            head_d = head_inc;
          end else begin
            hc_d = hc_q + 1'b1;
          end
        end else if (hc_q != '0) begin
          emit = 1'b1;
          ev = held_q[head_q];
          head_d = head_inc;
          hc_d = hc_q - 1'b1;
        end else begin
          emit = 1'b1;
          adv = 1'b1;
        end
        if (adv) begin
          if (k_q == 2'd0) begin
            if (ws) begin
              if (has_b) begin
                sw_d = 1'b1;
              end
            end else begin
              sw_d = 1'b0;
              cs_d = 1'b1;
            end
          end
          if ({1'b0, k_q} + 3'd1 >= nb) begin
            k_d = 2'd0;
            if ({1'b0, i_q} + 3'd1 >= job_i.cnt) begin
              i_d = 2'd0;
              fin = 1'b1;
            end else begin
              i_d = i_q + 2'd1;
            end
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      if (fin && !job_i.last) begin
        pop_o = 1'b1;
      end
      if (emit) begin
        if (!job_i.last) begin
          load = 1'b1;
          ld_byte = ev;
        end else if (fin) begin
          if (lbv_q) begin
            load = 1'b1;
            lb_d = ev;
            go_end = 1'b1;
          end else begin
            load = 1'b1;
            ld_byte = ev;
            ld_end = 1'b1;
            pop_o = 1'b1;
          end
        end else begin
          load = lbv_q;
          lb_d = ev;
          lbv_d = 1'b1;
        end
      end else if (fin && job_i.last) begin
        go_end = 1'b1;
      end
      if (fin && job_i.last) begin
        cs_d = 1'b0;
        sw_d = 1'b0;
        lead_d = 1'b1;
        hc_d = '0;
      end
    end else if (st_q == BK_END && free) begin
      load = 1'b1;
      ld_byte = lbv_q ? lb_q : 8'h00;
      ld_present = lbv_q;
      ld_end = 1'b1;
      lbv_d = 1'b0;
      pop_o = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_RUN: if (go_end) begin
        st_d = BK_END;
      end
      BK_END: if (free) begin
        st_d = BK_RUN;
      end
      default: st_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_RUN;
      i_q <= 2'd0;
      k_q <= 2'd0;
      cs_q <= 1'b0;
      sw_q <= 1'b0;
      lead_q <= 1'b1;
      head_q <= '0;
      hc_q <= '0;
      lbv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      i_q <= i_d;
      k_q <= k_d;
      cs_q <= cs_d;
      sw_q <= sw_d;
      lead_q <= lead_d;
      head_q <= head_d;
      hc_q <= hc_d;
      lbv_q <= lbv_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q <= lb_d;
    if (held_we) begin
      held_q[held_wa] <= held_wd;
    end
    if (load) begin
      ob_q <= ld_byte;
      ob_present_q <= ld_present;
      oe_q <= ld_end;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o = ob_q;
  assign byte_present_o = ob_present_q;
  assign key_end_o = oe_q;

endmodule

/* design/utf8_match_key_normalizer_unit.sv */
// Top level of the UTF-8 match key normalizer.
// A key enters one byte per transfer with its last flag, and the normalized key leaves one
// byte per transfer; the final result of each key carries key_end, and a key whose last
// byte yields nothing ends with a bare end marker (byte_present low). The decoder takes a
// byte every cycle while its two-entry job queue has room. The output sequencer works
// through each code point, or each encoded byte of a multi-byte code point, in turn and
// releases held separators one at a time, so plain ASCII without held separators runs
// at one byte per cycle while the output is not stalled; the last step of a key can be
// followed by a step in the end state that marks its final byte after a later result is
// ruled out.
module utf8_match_key_normalizer_unit import umkn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       key_end_o
);

  logic q_full, q_push, q_pop, q_valid;
  job_t f_job, q_job;

  umkn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .job_o      (f_job)
  );

  umkn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (f_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  umkn_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .key_end_o      (key_end_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("job queue read while empty");

  a_marker_ends_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> key_end_o)
    else $error("bare marker without key end");

  a_job_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (f_job.cnt <= 3'd4) && (f_job.cnt != 3'd0 || f_job.last))
    else $error("malformed job");

endmodule
